[rtl/jsrs_pkg.sv]
// Package with the shared constants, codes and types of the joint slew ramp sequencer.
`timescale 1ns / 1ps

package jsrs_pkg;

    // Number of joints and the width of an index into the joint banks.
    localparam int JOINTS = 15;
    localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // Field widths of the request and result items.
    localparam int POS_W  = 16;
    localparam int SPD_W  = 16;
    localparam int DT_W   = 20;
    localparam int REQ_W  = 3;
    localparam int JNUM_W = 4;

    // Step = (speed * dt) >> 13, kept wide enough that it never saturates.
    localparam int PROD_W     = SPD_W + DT_W;
    localparam int STEP_SHIFT = 13;
    localparam int STEP_W     = PROD_W - STEP_SHIFT;

    // Fully open position (1.0) and the gap under which a joint snaps to its goal.
    localparam logic [POS_W-1:0] ONE_POS  = POS_W'(32768);
    localparam logic [POS_W-1:0] SNAP_GAP = POS_W'(32);

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_STAGE = 3'd0,
        REQ_CLOSE = 3'd1,
        REQ_OPEN  = 3'd2,
        REQ_TICK  = 3'd3,
        REQ_RESET = 3'd4
    } t_req;

    // Animation mode of the hand.
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_CLOSING = 4'b0010,
        MODE_HOLDING = 4'b0100,
        MODE_OPENING = 4'b1000
    } t_mode;

    // What the ramp unit does to each joint during a sweep.
    typedef enum logic [1:0] {
        KIND_RAMP  = 2'd0,
        KIND_HOLD  = 2'd1,
        KIND_RESET = 2'd2
    } t_kind;

    // Control of the joint banks from the sequencer.
    typedef struct packed {
        logic              stage_we;
        logic [JIDX_W-1:0] stage_idx;
        logic [POS_W-1:0]  stage_data;
        logic [JIDX_W-1:0] idx;
        logic              cur_we;
        logic [POS_W-1:0]  cur_data;
        logic              goal_we;
        logic              goal_open;
    } t_bank_ctrl;

    // One result item as held in the output register.
    typedef struct packed {
        logic              hand_left;
        logic [JNUM_W-1:0] joint_number;
        logic [POS_W-1:0]  joint_position;
        logic              pose_valid;
        logic              animating;
        logic              clear_override;
        logic              last_item;
    } t_result;

endpackage

[rtl/jsrs_req_if.sv]
// Valid/ready channel interfaces for requests, results and the configuration write.
`timescale 1ns / 1ps

interface jsrs_req_if;
    logic                        valid;
    logic                        ready;
    logic [jsrs_pkg::REQ_W-1:0]  req_type;
    logic                        is_left;
    logic [jsrs_pkg::JNUM_W-1:0] joint_index;
    logic [jsrs_pkg::POS_W-1:0]  target_value;
    logic [jsrs_pkg::SPD_W-1:0]  ramp_speed;
    logic [jsrs_pkg::DT_W-1:0]   delta_time;

    modport source (output valid, req_type, is_left, joint_index, target_value,
                    ramp_speed, delta_time, input ready);
    modport sink   (input valid, req_type, is_left, joint_index, target_value,
                    ramp_speed, delta_time, output ready);
endinterface

interface jsrs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hand_left;
    logic [jsrs_pkg::JNUM_W-1:0] joint_number;
    logic [jsrs_pkg::POS_W-1:0]  joint_position;
    logic                        pose_valid;
    logic                        animating;
    logic                        clear_override;
    logic                        last_item;

    modport source (output valid, hand_left, joint_number, joint_position, pose_valid,
                    animating, clear_override, last_item, input ready);
    modport sink   (input valid, hand_left, joint_number, joint_position, pose_valid,
                    animating, clear_override, last_item, output ready);
endinterface

interface jsrs_cfg_if;
    logic valid;
    logic ready;
    logic keep_override;

    modport source (output valid, keep_override, input ready);
    modport sink   (input valid, keep_override, output ready);
endinterface

[rtl/jsrs_joint_bank.sv]
// Joint banks: current positions, goals and the staged targets.
`timescale 1ns / 1ps

module jsrs_joint_bank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jsrs_pkg::t_bank_ctrl        i_ctrl,
    output logic [jsrs_pkg::POS_W-1:0]  o_cur,
    output logic [jsrs_pkg::POS_W-1:0]  o_goal
);

    logic [jsrs_pkg::POS_W-1:0] r_cur    [jsrs_pkg::JOINTS];
    logic [jsrs_pkg::POS_W-1:0] r_goal   [jsrs_pkg::JOINTS];
    logic [jsrs_pkg::POS_W-1:0] r_staged [jsrs_pkg::JOINTS];

    // Current positions and goals come up fully open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < jsrs_pkg::JOINTS; i++) begin
                r_cur[i]  <= jsrs_pkg::ONE_POS;
                r_goal[i] <= jsrs_pkg::ONE_POS;
            end
        end else begin
            if (i_ctrl.cur_we) begin
                r_cur[i_ctrl.idx] <= i_ctrl.cur_data;
            end
            if (i_ctrl.goal_we) begin
                r_goal[i_ctrl.idx] <= i_ctrl.goal_open ? jsrs_pkg::ONE_POS
                                                       : r_staged[i_ctrl.idx];
            end
        end
    end

    // Staged targets hold whatever was last written; they are not cleared.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.stage_we) begin
            r_staged[i_ctrl.stage_idx] <= i_ctrl.stage_data;
        end
    end

    assign o_cur  = r_cur[i_ctrl.idx];
    assign o_goal = r_goal[i_ctrl.idx];

endmodule

[rtl/jsrs_ramp_alu.sv]
// Shared ramp unit: moves one joint toward its goal by the step, capped and snapped.
`timescale 1ns / 1ps

module jsrs_ramp_alu (
    input  jsrs_pkg::t_kind              i_kind,
    input  logic [jsrs_pkg::POS_W-1:0]   i_cur,
    input  logic [jsrs_pkg::POS_W-1:0]   i_goal,
    input  logic [jsrs_pkg::STEP_W-1:0]  i_step,
    output logic [jsrs_pkg::POS_W-1:0]   o_next,
    output logic                         o_reached
);

    logic                       w_up;
    logic [jsrs_pkg::POS_W-1:0] w_gap;
    logic                       w_near;
    logic                       w_cap;

    // Distance to the goal and the two decisions that depend on it.
    assign w_up   = i_goal > i_cur;
    assign w_gap  = w_up ? (i_goal - i_cur) : (i_cur - i_goal);
    assign w_near = w_gap <= jsrs_pkg::SNAP_GAP;
    assign w_cap  = i_step >= jsrs_pkg::STEP_W'(w_gap);

    // Pick the new position; the step is below the gap when it is added.
    always_comb begin
        o_next    = i_cur;
        o_reached = 1'b1;
        case (i_kind)
            jsrs_pkg::KIND_RESET: begin
                o_next = jsrs_pkg::ONE_POS;
            end
            jsrs_pkg::KIND_RAMP: begin
                o_reached = w_near;
                if (w_near || w_cap) begin
                    o_next = i_goal;
                end else if (w_up) begin
                    o_next = i_cur + i_step[jsrs_pkg::POS_W-1:0];
                end else begin
                    o_next = i_cur - i_step[jsrs_pkg::POS_W-1:0];
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

[rtl/joint_slew_ramp_sequencer_unit.sv]
// Top level of the joint slew ramp sequencer: request decode, sequencer and result register.
// A ramping tick passes ST_STEP for the step product before the joint walk in ST_WALK.
// Holding ticks and force resets go straight to ST_WALK; close and open use ST_LOAD.
// Idle ticks pass ST_BLANK, stage requests end when taken; results are registered in r_out.
// The one ramp unit and one bank read port per cycle set the pace; output stalls hold the walk.
// Synchronous active-low reset opens all joints, returns to idle; staged targets are kept.
`timescale 1ns / 1ps

module joint_slew_ramp_sequencer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsrs_cfg_if.sink   i_cfg,
    jsrs_req_if.sink   i_req,
    jsrs_res_if.source o_res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_STEP  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_BLANK = 5'b10000
    } t_state;

    localparam logic [jsrs_pkg::JIDX_W-1:0] LAST_IDX = jsrs_pkg::JIDX_W'(jsrs_pkg::JOINTS - 1);

    t_state                          r_state;
    t_state                          n_state;
    jsrs_pkg::t_mode                 r_mode;
    jsrs_pkg::t_kind                 r_kind;
    logic                            r_keep;
    logic                            r_left;
    logic                            r_goal_open;
    logic                            r_reached;
    logic [jsrs_pkg::JIDX_W-1:0]     r_idx;
    logic [jsrs_pkg::SPD_W-1:0]      r_speed;
    logic [jsrs_pkg::DT_W-1:0]       r_dt;
    logic [jsrs_pkg::STEP_W-1:0]     r_step;
    jsrs_pkg::t_result               r_out;
    logic                            r_out_valid;

    logic                            w_accept;
    logic                            w_slot;
    logic                            w_last;
    logic                            w_all;
    logic                            w_idx_ok;
    logic [jsrs_pkg::PROD_W-1:0]     w_prod;
    logic [jsrs_pkg::POS_W-1:0]      w_cur;
    logic [jsrs_pkg::POS_W-1:0]      w_goal;
    logic [jsrs_pkg::POS_W-1:0]      w_next;
    logic                            w_alu_reached;
    jsrs_pkg::t_bank_ctrl            w_ctrl;

    // Handshakes: requests are taken only in idle; results leave through one register.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot      = !r_out_valid || o_res.ready;
    assign w_last      = (r_idx == LAST_IDX);
    assign w_idx_ok    = 32'(i_req.joint_index) < jsrs_pkg::JOINTS;
    assign w_all       = r_reached && w_alu_reached;

    // Step product of the latched speed and the tick length.
    assign w_prod = jsrs_pkg::PROD_W'(r_speed) * jsrs_pkg::PROD_W'(r_dt);

    // Bank control for staging, goal loads and position write-back.
    always_comb begin
        w_ctrl            = '0;
        w_ctrl.stage_we   = w_accept && (jsrs_pkg::t_req'(i_req.req_type) == jsrs_pkg::REQ_STAGE)
                            && w_idx_ok;
        w_ctrl.stage_idx  = jsrs_pkg::JIDX_W'(i_req.joint_index);
        w_ctrl.stage_data = i_req.target_value;
        w_ctrl.idx        = r_idx;
        w_ctrl.cur_we     = (r_state == ST_WALK) && w_slot && (r_kind != jsrs_pkg::KIND_HOLD);
        w_ctrl.cur_data   = w_next;
        w_ctrl.goal_we    = (r_state == ST_LOAD)
                            || ((r_state == ST_WALK) && w_slot
                                && (r_kind == jsrs_pkg::KIND_RESET));
        w_ctrl.goal_open  = r_goal_open;
    end

    jsrs_joint_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_cur   (w_cur),
        .o_goal  (w_goal)
    );

    jsrs_ramp_alu u_alu (
        .i_kind    (r_kind),
        .i_cur     (w_cur),
        .i_goal    (w_goal),
        .i_step    (r_step),
        .o_next    (w_next),
        .o_reached (w_alu_reached)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (jsrs_pkg::t_req'(i_req.req_type))
                        jsrs_pkg::REQ_CLOSE, jsrs_pkg::REQ_OPEN: n_state = ST_LOAD;
                        jsrs_pkg::REQ_TICK: begin
                            if (r_mode == jsrs_pkg::MODE_IDLE) begin
                                n_state = ST_BLANK;
                            end else if (r_mode == jsrs_pkg::MODE_HOLDING) begin
                                n_state = ST_WALK;
                            end else begin
                                n_state = ST_STEP;
                            end
                        end
                        jsrs_pkg::REQ_RESET: n_state = ST_WALK;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_STEP:  n_state = ST_WALK;
            ST_WALK:  n_state = (w_slot && w_last) ? ST_IDLE : ST_WALK;
            ST_LOAD:  n_state = w_last ? ST_IDLE : ST_LOAD;
            ST_BLANK: n_state = w_slot ? ST_IDLE : ST_BLANK;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, mode, kind, speed, joint counter, reached flag, config bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= jsrs_pkg::MODE_IDLE;
            r_kind    <= jsrs_pkg::KIND_RAMP;
            r_keep    <= 1'b0;
            r_idx     <= '0;
            r_speed   <= '0;
            r_reached <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_keep <= i_cfg.keep_override;
            end
            if (w_accept) begin
                r_idx     <= '0;
                r_reached <= 1'b1;
                unique case (jsrs_pkg::t_req'(i_req.req_type))
                    jsrs_pkg::REQ_CLOSE: begin
                        r_speed <= i_req.ramp_speed;
                        r_mode  <= jsrs_pkg::MODE_CLOSING;
                    end
                    jsrs_pkg::REQ_OPEN: begin
                        r_speed <= i_req.ramp_speed;
                        r_mode  <= jsrs_pkg::MODE_OPENING;
                    end
                    jsrs_pkg::REQ_TICK: begin
                        r_kind <= (r_mode == jsrs_pkg::MODE_HOLDING) ? jsrs_pkg::KIND_HOLD
                                                                     : jsrs_pkg::KIND_RAMP;
                    end
                    jsrs_pkg::REQ_RESET: begin
                        r_kind <= jsrs_pkg::KIND_RESET;
                        r_mode <= jsrs_pkg::MODE_IDLE;
                    end
                    default: begin
                        r_kind <= r_kind;
                    end
                endcase
            end
            // Goal loads advance one joint per cycle.
            if (r_state == ST_LOAD) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
            end
            // Joint walk advances when the result register can take an item.
            if ((r_state == ST_WALK) && w_slot) begin
                r_idx     <= w_last ? '0 : r_idx + 1'b1;
                r_reached <= w_all;
                if (w_last && (r_kind == jsrs_pkg::KIND_RAMP) && w_all) begin
                    r_mode <= (r_mode == jsrs_pkg::MODE_CLOSING) ? jsrs_pkg::MODE_HOLDING
                                                                 : jsrs_pkg::MODE_IDLE;
                end
            end
        end
    end

    // Request payload latches and the registered step.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left      <= i_req.is_left;
            r_dt        <= i_req.delta_time;
            r_goal_open <= (jsrs_pkg::t_req'(i_req.req_type) != jsrs_pkg::REQ_CLOSE);
        end
        if (r_state == ST_STEP) begin
            r_step <= w_prod[jsrs_pkg::PROD_W-1:jsrs_pkg::STEP_SHIFT];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (((r_state == ST_WALK) || (r_state == ST_BLANK)) && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: a joint position during a walk, an empty item for an idle tick.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WALK) && w_slot) begin
            r_out.hand_left      <= r_left;
            r_out.joint_number   <= jsrs_pkg::JNUM_W'(r_idx);
            r_out.joint_position <= w_next;
            r_out.pose_valid     <= 1'b1;
            r_out.animating      <= (r_kind != jsrs_pkg::KIND_RESET);
            r_out.clear_override <= w_last
                                    && ((r_kind == jsrs_pkg::KIND_RESET)
                                        || ((r_kind == jsrs_pkg::KIND_RAMP) && w_all
                                            && (r_mode == jsrs_pkg::MODE_OPENING)
                                            && !r_keep));
            r_out.last_item      <= w_last;
        end else if ((r_state == ST_BLANK) && w_slot) begin
            r_out <= '{hand_left: r_left, joint_number: '0, joint_position: '0,
                       pose_valid: 1'b0, animating: 1'b0, clear_override: 1'b0,
                       last_item: 1'b1};
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.hand_left      = r_out.hand_left;
    assign o_res.joint_number   = r_out.joint_number;
    assign o_res.joint_position = r_out.joint_position;
    assign o_res.pose_valid     = r_out.pose_valid;
    assign o_res.animating      = r_out.animating;
    assign o_res.clear_override = r_out.clear_override;
    assign o_res.last_item      = r_out.last_item;

endmodule

[rtl/jsrs_checker.sv]
// Port-level checker for the joint slew ramp sequencer and its bind to the top level.
`timescale 1ns / 1ps

module jsrs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic [jsrs_pkg::REQ_W-1:0]  i_req_type,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [jsrs_pkg::JNUM_W-1:0] i_res_number,
    input logic [jsrs_pkg::POS_W-1:0]  i_res_position,
    input logic                        i_res_pose_valid,
    input logic                        i_res_animating,
    input logic                        i_res_clear,
    input logic                        i_res_last
);

    // A stalled result stays offered with the same position.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_position))
        else $error("stalled result changed or vanished");

    // An item without a pose is the lone, empty result of an idle tick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_pose_valid |->
            i_res_last && !i_res_animating && !i_res_clear
            && (i_res_number == '0) && (i_res_position == '0))
        else $error("empty result is not a clean final item");

    // The override release only comes with the final result of a request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_clear |-> i_res_last)
        else $error("clear_override on a result that is not last");

    // Close, open, tick and force reset all keep the block busy in the cycle after they are taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready
            && ((i_req_type == jsrs_pkg::REQ_CLOSE) || (i_req_type == jsrs_pkg::REQ_OPEN)
                || (i_req_type == jsrs_pkg::REQ_TICK) || (i_req_type == jsrs_pkg::REQ_RESET))
        |=> !i_req_ready)
        else $error("request taken while a previous one is still in work");

endmodule

bind joint_slew_ramp_sequencer_unit jsrs_checker u_jsrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_type       (i_req.req_type),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_number     (o_res.joint_number),
    .i_res_position   (o_res.joint_position),
    .i_res_pose_valid (o_res.pose_valid),
    .i_res_animating  (o_res.animating),
    .i_res_clear      (o_res.clear_override),
    .i_res_last       (o_res.last_item)
);
